/* design/modbus_rtu_response_checker_core_assert.svh */
// Assertion macros for the checker core modules; mrc_fifo is the one that uses them.
// Each macro expands to one labeled concurrent assertion on the rising clock.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_CORE_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_CORE_ASSERT_SVH

// Checked only outside of reset.
`define MRC_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, also during reset.
`define MRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, codes and the CRC-16 byte update shared by the response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam int          MIN_FRAME = 8;
   localparam int          HEAD_LEN  = 7;
   localparam logic [7:0]  DEFAULT_FUNCTION = 8'h04;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_CRC   = 3'd2;
   localparam logic [2:0] ST_FUNC  = 3'd3;
   localparam logic [2:0] ST_OVER  = 3'd4;

   localparam int          CSR_INDEX_W = 1;
   localparam int          CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_FUNCTION    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_FUNCTION = 1'd1;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  frame_status;
      logic [7:0]  device_address;
      logic [7:0]  function_code;
      logic [15:0] temperature_tenths;
      logic [15:0] humidity_tenths;
   } rsp_type;

   // One finished frame as the front end classified it.
   typedef struct packed {
      logic        too_short;
      logic        overflow;
      logic        crc_match;
      logic [7:0]  device_address;
      logic [7:0]  function_code;
      logic [15:0] temperature_tenths;
      logic [15:0] humidity_tenths;
   } frame_rec_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* design/modbus_rtu_response_checker_core.sv */
// A frame_end byte's record goes into the record queue, then into the result register.
// Throughput: one byte per cycle while the queue has room; the CRC-16 update is combinational.
// A two-entry record queue and the result register let bytes keep flowing while a result waits.
// Reset is synchronous and active high; it clears the frame state, the queue, the result
// valid flag and restores check_function to 0 and expected_function to 0x04.
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_core
// Checks received Modbus RTU response frames and reports status and data words.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_core #(
   parameter int MAX_FRAME = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  mrc_pkg::req_type                req_data,
   output logic                            req_stall,
   output logic                            rsp_valid,
   output mrc_pkg::rsp_type                rsp_data,
   input  logic                            rsp_stall,
   input  logic                            csr_wr_en,
   input  logic [mrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   mrc_pkg::queue_status_type queue_status;
   mrc_pkg::frame_rec_type    push_rec, pop_rec;
   logic                      push, pop;

   mrc_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .queue_status (queue_status),
      .push         (push),
      .push_rec     (push_rec)
   );

   mrc_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_rec     (push_rec),
      .pop          (pop),
      .pop_rec      (pop_rec),
      .queue_status (queue_status)
   );

   mrc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_status (queue_status),
      .pop_rec      (pop_rec),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_stall    (rsp_stall)
   );

endmodule

/* design/mrc_front.sv */
// ----------------------------------------------------------------------------
// mrc_front
// Accepts frame bytes, runs the CRC, keeps head and tail bytes and the count,
// and hands a classified frame record to the queue at frame end.
// ----------------------------------------------------------------------------
module mrc_front #(
   parameter int MAX_FRAME = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  mrc_pkg::req_type          req_data,
   output logic                      req_stall,
   input  mrc_pkg::queue_status_type queue_status,
   output logic                      push,
   output mrc_pkg::frame_rec_type    push_rec
);

   localparam int COUNT_W = $clog2(MAX_FRAME + 2);

   logic [15:0]        crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         tail_ff [2];
   logic [7:0]         tail_in [2];
   logic [7:0]         head_ff [mrc_pkg::HEAD_LEN];
   logic [7:0]         head_in [mrc_pkg::HEAD_LEN];
   logic               accept;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   // The two newest bytes are held back from the CRC since they may be the check word.
   always_comb begin
      crc_in   = (count_ff >= COUNT_W'(2)) ? mrc_pkg::crc_feed(crc_ff, tail_ff[0]) : crc_ff;
      count_in = (count_ff <= COUNT_W'(MAX_FRAME)) ? count_ff + COUNT_W'(1) : count_ff;
      tail_in[0] = tail_ff[1];
      tail_in[1] = req_data.rx_byte;
      for (int i = 0; i < mrc_pkg::HEAD_LEN; i++) begin
         head_in[i] = (count_ff == COUNT_W'(i)) ? req_data.rx_byte : head_ff[i];
      end
   end

   always_comb begin
      push = accept && req_data.frame_end;
      push_rec.too_short          = count_in < COUNT_W'(mrc_pkg::MIN_FRAME);
      push_rec.overflow           = count_in > COUNT_W'(MAX_FRAME);
      push_rec.crc_match          = {req_data.rx_byte, tail_ff[1]} == crc_in;
      push_rec.device_address     = head_in[0];
      push_rec.function_code      = head_in[1];
      push_rec.temperature_tenths = {head_in[3], head_in[4]};
      push_rec.humidity_tenths    = {head_in[5], head_in[6]};
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.frame_end)) begin
         crc_ff   <= mrc_pkg::CRC_INIT;
         count_ff <= '0;
         tail_ff[0] <= '0;
         tail_ff[1] <= '0;
         for (int i = 0; i < mrc_pkg::HEAD_LEN; i++) begin
            head_ff[i] <= '0;
         end
      end else if (accept) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         tail_ff[0] <= tail_in[0];
         tail_ff[1] <= tail_in[1];
         for (int i = 0; i < mrc_pkg::HEAD_LEN; i++) begin
            head_ff[i] <= head_in[i];
         end
      end
   end

endmodule

/* design/mrc_fifo.sv */
// ----------------------------------------------------------------------------
// mrc_fifo
// Short queue of frame records between the front and back ends.
// ----------------------------------------------------------------------------
`include "modbus_rtu_response_checker_core_assert.svh"

module mrc_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mrc_pkg::frame_rec_type    push_rec,
   input  logic                      pop,
   output mrc_pkg::frame_rec_type    pop_rec,
   output mrc_pkg::queue_status_type queue_status
);

   localparam int DEPTH = mrc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mrc_pkg::frame_rec_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign queue_status.full      = count_ff == CNT_W'(DEPTH);
   assign queue_status.not_empty = count_ff != '0;
   assign do_push = push && !queue_status.full;
   assign do_pop  = pop && queue_status.not_empty;
   assign pop_rec = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

   `MRC_ASSERT_RST(a_no_push_when_full, clock, reset, !(push && queue_status.full), "record pushed into a full queue")
   `MRC_ASSERT_RST(a_fill_grows, clock, reset, (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "queue fill did not grow on push")
   `MRC_ASSERT_RST(a_fill_bounded, clock, reset, count_ff <= CNT_W'(DEPTH), "queue fill beyond its depth")

endmodule

/* design/mrc_back.sv */
// ----------------------------------------------------------------------------
// mrc_back
// Holds the configuration registers, resolves the frame status and drives
// the result register.
// ----------------------------------------------------------------------------
module mrc_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [mrc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mrc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  mrc_pkg::queue_status_type            queue_status,
   input  mrc_pkg::frame_rec_type               pop_rec,
   output logic                                 pop,
   output logic                                 rsp_valid,
   output mrc_pkg::rsp_type                     rsp_data,
   input  logic                                 rsp_stall
);

   logic             check_function_ff;
   logic [7:0]       expected_function_ff;
   logic             rsp_valid_ff;
   mrc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // A new record moves up whenever the result register is empty or being taken.
   assign pop       = queue_status.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_function_ff    <= 1'b0;
         expected_function_ff <= mrc_pkg::DEFAULT_FUNCTION;
      end else if (csr_wr_en) begin
         case (csr_index)
            mrc_pkg::CSR_CHECK_FUNCTION:    check_function_ff    <= csr_wdata[0];
            mrc_pkg::CSR_EXPECTED_FUNCTION: expected_function_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_data_in.device_address     = pop_rec.device_address;
      rsp_data_in.function_code      = pop_rec.function_code;
      rsp_data_in.temperature_tenths = pop_rec.temperature_tenths;
      rsp_data_in.humidity_tenths    = pop_rec.humidity_tenths;
      if (pop_rec.too_short) begin
         rsp_data_in.frame_status = mrc_pkg::ST_SHORT;
      end else if (pop_rec.overflow) begin
         rsp_data_in.frame_status = mrc_pkg::ST_OVER;
      end else if (check_function_ff && (pop_rec.function_code != expected_function_ff)) begin
         rsp_data_in.frame_status = mrc_pkg::ST_FUNC;
      end else if (!pop_rec.crc_match) begin
         rsp_data_in.frame_status = mrc_pkg::ST_CRC;
      end else begin
         rsp_data_in.frame_status = mrc_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
